FILE: design/gkv_pkg.sv
// ----------------------------------------------------------------------------
// gkv_pkg
// Shared types, constants, the log2 table and the log2 helper for the
// Garman-Klass variance sum unit.
// ----------------------------------------------------------------------------
package gkv_pkg;

  // log2 mantissa table size, power of two
  localparam int LOG_TABLE_ENTRIES = 256;
  localparam int IDX_W             = $clog2(LOG_TABLE_ENTRIES);

  // work queue depth between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);

  // ln2 in Q28 and (2ln2-1) in Q32
  localparam logic [27:0] LN2_Q28 = 28'd186065279;
  localparam logic [30:0] K_Q32   = 31'd1659121648;

  // input item
  typedef struct packed {
    logic [31:0] close_price;
    logic [31:0] high_price;
    logic [31:0] low_price;
    logic        first_bar;
    logic        last_bar;
  } gkv_bar_t;

  // result item
  typedef struct packed {
    logic [63:0] variance_sum;
    logic        sum_valid;
  } gkv_result_t;

  // classified bar handed from front to back
  typedef struct packed {
    logic [31:0] open_price;
    logic [31:0] close_price;
    logic [31:0] high_price;
    logic [31:0] low_price;
    logic        counted;
    logic        last_bar;
  } gkv_work_t;

  // back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOG,
    ST_DIFF,
    ST_LN1,
    ST_LN2,
    ST_SQ1,
    ST_SQ2,
    ST_SQR,
    ST_KH,
    ST_KL,
    ST_ACC
  } gkv_state_t;

  typedef logic [29:0] log_tab_t [LOG_TABLE_ENTRIES];

  // log2(1 + i/N) in Q0.30, built bit-serially by repeated squaring
  function automatic log_tab_t build_log_tab();
    log_tab_t     t;
    logic [127:0] z;
    logic [29:0]  acc;
    for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
      z   = (128'(LOG_TABLE_ENTRIES + i) << 31) / 128'(LOG_TABLE_ENTRIES);
      acc = '0;
      for (int b = 0; b < 30; b++) begin
        z   = (z * z) >> 31;
        acc = {acc[28:0], 1'b0};
        if (z >= (128'd1 << 32)) begin
          acc[0] = 1'b1;
          z      = z >> 1;
        end
      end
      t[i] = acc;
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

  // log2 of a nonzero raw word in Q5.30: leading-one position plus table
  function automatic logic [34:0] log2_q30(logic [31:0] x);
    logic [4:0]       p;
    logic [32:0]      sh;
    logic [31:0]      f;
    logic [IDX_W-1:0] idx;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) p = 5'(i);
    end
    sh  = {x, 1'b0} << (5'd31 - p);
    f   = sh[31:0];
    idx = f[31 -: IDX_W];
    return {p, LOG_TAB[idx]};
  endfunction

endpackage

FILE: design/gkv_queue.sv
// ----------------------------------------------------------------------------
// gkv_queue
// Small register queue carrying classified bars from front to back.
// ----------------------------------------------------------------------------
module gkv_queue import gkv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  gkv_work_t push_item,
  input  logic      pop,
  output gkv_work_t pop_item,
  output logic      full,
  output logic      empty
);

  gkv_work_t       entries [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;
  logic [QP_W:0]   count;

  assign full     = (count == (QP_W + 1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/gkv_front.sv
// ----------------------------------------------------------------------------
// gkv_front
// Accepts bars, resolves the open price and flags bars with a missing value.
// ----------------------------------------------------------------------------
module gkv_front import gkv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      bar_valid,
  output logic      bar_stall,
  input  gkv_bar_t  bar,
  input  logic      full,
  output logic      push,
  output gkv_work_t push_item
);

  logic [31:0] previous_close;
  logic [31:0] open_price;

  assign bar_stall = full;
  assign push      = bar_valid && !full;

  // open is own close on the first bar of a row
  assign open_price = bar.first_bar ? bar.close_price : previous_close;

  // classify
  always_comb begin
    push_item.open_price  = open_price;
    push_item.close_price = bar.close_price;
    push_item.high_price  = bar.high_price;
    push_item.low_price   = bar.low_price;
    push_item.counted     = (open_price != '0) && (bar.close_price != '0) &&
                            (bar.high_price != '0) && (bar.low_price != '0);
    push_item.last_bar    = bar.last_bar;
  end

  // previous close tracks every accepted bar
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_close <= '0;
    end else if (push) begin
      previous_close <= bar.close_price;
    end
  end

endmodule

FILE: design/gkv_back.sv
// ----------------------------------------------------------------------------
// gkv_back
// Sequencer with one shared multiplier: logs, squares, weighting, saturating
// accumulation and the result register.
// ----------------------------------------------------------------------------
module gkv_back import gkv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  gkv_work_t   pop_item,
  output logic        pop,
  output logic        result_valid,
  input  logic        result_stall,
  output gkv_result_t result
);

  gkv_state_t  state, state_next;
  gkv_work_t   cur;
  logic [34:0] lg_h, lg_l, lg_c, lg_o;
  logic [34:0] d1, d2;
  logic [32:0] a, b;
  logic [52:0] term1;
  logic [51:0] sq;
  logic [58:0] hk;
  logic [67:0] prod;
  logic [63:0] running_sum;
  logic        any_counted;

  logic [34:0] mul_a;
  logic [32:0] mul_b;
  logic [63:0] term2;
  logic [63:0] variance;
  logic [64:0] sum_wide;
  logic [63:0] sum_sat;
  logic [63:0] sum_new;
  logic        any_new;
  logic        out_free;
  logic        acc_go;

  assign out_free = !result_valid || !result_stall;
  assign acc_go   = !cur.last_bar || out_free;
  assign pop      = (state == ST_IDLE) && !empty;

  // shared multiplier operand select; the low weighting product is held
  // through the accumulate step while it waits on the result register
  always_comb begin
    case (state)
      ST_LN1:  begin mul_a = d1;                mul_b = 33'(LN2_Q28); end
      ST_LN2:  begin mul_a = d2;                mul_b = 33'(LN2_Q28); end
      ST_SQ1:  begin mul_a = 35'(a);            mul_b = a;            end
      ST_SQ2:  begin mul_a = 35'(b);            mul_b = b;            end
      ST_KH:   begin mul_a = 35'(sq[51:24]);    mul_b = 33'(K_Q32);   end
      ST_KL, ST_ACC: begin
        mul_a = 35'(sq[23:0]);
        mul_b = 33'(K_Q32);
      end
      default: begin mul_a = '0;                mul_b = '0;           end
    endcase
  end

  // weighted second term, variance clip and saturating sum
  always_comb begin
    term2 = 64'(hk >> 8) +
            (((64'(hk[7:0]) << 24) + 64'(prod[54:0]) + 64'h8000_0000) >> 32);
    variance = (64'(term1) > term2) ? 64'(term1) - term2 : '0;
    sum_wide = {1'b0, running_sum} + {1'b0, variance};
    sum_sat  = sum_wide[64] ? '1 : sum_wide[63:0];
    sum_new  = cur.counted ? sum_sat : running_sum;
    any_new  = cur.counted || any_counted;
  end

  // next state
  always_comb begin
    case (state)
      ST_IDLE: state_next = empty ? ST_IDLE : ST_LOG;
      ST_LOG:  state_next = ST_DIFF;
      ST_DIFF: state_next = ST_LN1;
      ST_LN1:  state_next = ST_LN2;
      ST_LN2:  state_next = ST_SQ1;
      ST_SQ1:  state_next = ST_SQ2;
      ST_SQ2:  state_next = ST_SQR;
      ST_SQR:  state_next = ST_KH;
      ST_KH:   state_next = ST_KL;
      ST_KL:   state_next = ST_ACC;
      ST_ACC:  state_next = acc_go ? ST_IDLE : ST_ACC;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= 68'(mul_a) * 68'(mul_b);
    case (state)
      ST_IDLE: if (!empty) cur <= pop_item;
      ST_LOG: begin
        lg_h <= log2_q30(cur.high_price);
        lg_l <= log2_q30(cur.low_price);
        lg_c <= log2_q30(cur.close_price);
        lg_o <= log2_q30(cur.open_price);
      end
      ST_DIFF: begin
        d1 <= (lg_h >= lg_l) ? lg_h - lg_l : lg_l - lg_h;
        d2 <= (lg_c >= lg_o) ? lg_c - lg_o : lg_o - lg_c;
      end
      ST_LN2:  a     <= 33'((prod + (68'd1 << 30)) >> 31);
      ST_SQ1:  b     <= 33'((prod + (68'd1 << 30)) >> 31);
      ST_SQ2:  term1 <= 53'((prod + (68'd1 << 14)) >> 15);
      ST_SQR:  sq    <= 52'((prod + (68'd1 << 13)) >> 14);
      ST_KL:   hk    <= prod[58:0];
      default: ;
    endcase
  end

  // running sum and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      any_counted  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) result_valid <= 1'b0;
      if (state == ST_ACC && acc_go) begin
        if (cur.last_bar) begin
          result_valid        <= 1'b1;
          result.sum_valid    <= any_new && (sum_new != '0);
          result.variance_sum <= (any_new && (sum_new != '0)) ? sum_new : '0;
          running_sum         <= '0;
          any_counted         <= 1'b0;
        end else begin
          running_sum <= sum_new;
          any_counted <= any_new;
        end
      end
    end
  end

  // a zero-flagged result carries a zero sum
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.sum_valid |-> result.variance_sum == '0)
    else $error("flagged-invalid result has nonzero sum");

  // pops only from a filled queue
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");

  // a new result only comes out of the accumulate step
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_ACC)
    else $error("result raised outside accumulate step");

endmodule

FILE: design/garman_klass_variance_sum_unit.sv
// ----------------------------------------------------------------------------
// garman_klass_variance_sum_unit
// Garman-Klass per-bar variance with a saturating sum per row of bars.
// ----------------------------------------------------------------------------
// Each bar passes through the back sequencer (log lookup, diff, then six
// passes through one shared multiplier and an accumulate step, which waits
// while a row result cannot be handed out); the sequencer takes a new bar
// only once the last one is accumulated, and a four-entry queue absorbs bursts.
// Synchronous reset clears previous close, running sum, queue and result valid.
module garman_klass_variance_sum_unit import gkv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        bar_valid,
  output logic        bar_stall,
  input  gkv_bar_t    bar,
  output logic        result_valid,
  input  logic        result_stall,
  output gkv_result_t result
);

  logic      push, pop, full, empty;
  gkv_work_t push_item, pop_item;

  // accept and classify
  gkv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .bar_valid (bar_valid),
    .bar_stall (bar_stall),
    .bar       (bar),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue
  gkv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (full),
    .empty     (empty)
  );

  // compute and accumulate
  gkv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .pop_item     (pop_item),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

FILE: dv/garman_klass_variance_sum_unit_test.sv
// ----------------------------------------------------------------------------
// garman_klass_variance_sum_unit_test
// Drives rows of price bars into the variance sum unit under random idling on
// both sides. Each result is checked against a local bit-accurate predictor,
// and a few directed rows also carry hand-written expected results.
// ----------------------------------------------------------------------------
module garman_klass_variance_sum_unit_test;
  import gkv_pkg::*;

  localparam int  N_RANDOM  = 700;
  localparam int  LIMIT     = 400000;
  localparam int  TAB_N     = 256;
  localparam logic [63:0] LN2_COEF = 64'd186065279;
  localparam logic [63:0] K_COEF   = 64'd1659121648;

  // idle phases
  typedef enum int { PH_NONE, PH_SEND, PH_RECV, PH_BOTH } idle_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        bar_valid = 1'b0;
  logic        bar_stall;
  gkv_bar_t    bar = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  gkv_result_t result;

  garman_klass_variance_sum_unit DUT (
    .clk(clk), .rst(rst), .bar_valid(bar_valid), .bar_stall(bar_stall), .bar(bar),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [31:0] mant_log [TAB_N];
  logic [31:0] last_close = '0;
  logic [63:0] row_sum = '0;
  logic        row_counted = 1'b0;

  gkv_result_t sums_due [$];
  int          errors = 0;
  int          cycles = 0;
  idle_phase_t phase = PH_NONE;

  // directed stimulus: row of bar plus optional typed-in result
  typedef struct {
    gkv_bar_t    b;
    logic        typed;
    gkv_result_t r;
  } row_t;
  row_t plan [$];

  // mantissa log2 table, repeated squaring
  initial begin
    logic [127:0] z;
    logic [31:0]  acc;
    for (int i = 0; i < TAB_N; i++) begin
      z = (128'(TAB_N + i) << 31) / TAB_N;
      acc = '0;
      for (int k = 0; k < 30; k++) begin
        z = (z * z) >> 31;
        acc = acc << 1;
        if (z >= (128'd1 << 32)) begin
          acc[0] = 1'b1;
          z = z >> 1;
        end
      end
      mant_log[i] = acc;
    end
  end

  function automatic logic [63:0] log2_fix(logic [31:0] x);
    int          p;
    logic [63:0] f;
    p = 0;
    for (int i = 0; i < 32; i++) if (x[i]) p = i;
    f = ({32'd0, x} << (32 - p)) & 64'hFFFF_FFFF;
    return (64'(p) << 30) + 64'(mant_log[(f * TAB_N) >> 32]);
  endfunction

  function automatic logic [63:0] ln_ratio(logic [31:0] a, logic [31:0] b);
    logic [63:0] la, lb, d;
    la = log2_fix(a);
    lb = log2_fix(b);
    d = (la >= lb) ? la - lb : lb - la;
    return (d * LN2_COEF + (64'd1 << 30)) >> 31;
  endfunction

  function automatic logic [63:0] garman_klass(logic [31:0] o, c, h, l);
    logic [63:0] a, b, t1, sq, hk, lk, t2;
    a = ln_ratio(h, l);
    b = ln_ratio(c, o);
    t1 = (a * a + (64'd1 << 14)) >> 15;
    sq = (b * b + (64'd1 << 13)) >> 14;
    hk = (sq >> 24) * K_COEF;
    lk = (sq & 64'hFF_FFFF) * K_COEF;
    t2 = (hk >> 8) + ((((hk & 64'hFF) << 24) + lk + (64'd1 << 31)) >> 32);
    return (t1 > t2) ? t1 - t2 : 64'd0;
  endfunction

  // advance predictor on an accepted bar
  task automatic predict_bar(gkv_bar_t b);
    logic [31:0] o;
    logic [63:0] v, s;
    gkv_result_t r;
    o = b.first_bar ? b.close_price : last_close;
    if (o != 0 && b.close_price != 0 && b.high_price != 0 && b.low_price != 0) begin
      v = garman_klass(o, b.close_price, b.high_price, b.low_price);
      s = row_sum + v;
      row_sum = (s < row_sum) ? '1 : s;
      row_counted = 1'b1;
    end
    last_close = b.close_price;
    if (b.last_bar) begin
      r.sum_valid = row_counted && row_sum != 0;
      r.variance_sum = r.sum_valid ? row_sum : 64'd0;
      sums_due.push_back(r);
      row_sum = '0;
      row_counted = 1'b0;
    end
  endtask

  function automatic gkv_bar_t mk(logic [31:0] c, h, l, logic f, e);
    gkv_bar_t b;
    b.close_price = c; b.high_price = h; b.low_price = l;
    b.first_bar = f; b.last_bar = e;
    return b;
  endfunction

  function automatic logic [31:0] rand_price();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'd0;
      2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      3: return $urandom_range(1, 8);
      default: return 32'h0001_0000 + $urandom_range(0, 32'h0008_0000);
    endcase
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("garman_klass_variance_sum_unit_test: errors");
      $finish;
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (phase == PH_RECV || phase == PH_BOTH)
      result_stall <= ($urandom_range(0, 99) < ((phase == PH_BOTH) ? 38 : 86));
    else result_stall <= 1'b0;
  end

  // result checking
  always @(posedge clk) begin
    gkv_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (sums_due.size() == 0) begin
        $error("result with none expected: variance_sum %h sum_valid %b",
               result.variance_sum, result.sum_valid);
        errors++;
      end else begin
        want = sums_due.pop_front();
        if (result.variance_sum !== want.variance_sum) begin
          $error("variance_sum expected %h actual %h", want.variance_sum,
                 result.variance_sum);
          errors++;
        end
        if (result.sum_valid !== want.sum_valid) begin
          $error("sum_valid expected %b actual %b", want.sum_valid, result.sum_valid);
          errors++;
        end
      end
    end
  end

  // send one bar, idling per phase
  task automatic send_bar(gkv_bar_t b);
    while ((phase == PH_SEND || phase == PH_BOTH) &&
           $urandom_range(0, 99) < ((phase == PH_BOTH) ? 38 : 86)) begin
      bar_valid <= 1'b0;
      @(posedge clk);
    end
    bar_valid <= 1'b1;
    bar <= b;
    @(posedge clk);
    while (bar_stall) @(posedge clk);
    predict_bar(b);
  endtask

  initial begin
    row_t        e;
    gkv_bar_t    b;
    int          len;
    int          k;
    gkv_result_t typed_r;
    logic [31:0] keep_close;
    logic [63:0] keep_sum;
    logic        keep_counted;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    e.typed = 1'b1; e.r = '0;
    e.b = mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b1); plan.push_back(e);
    e.b = mk(32'd0, 32'h0002_0000, 32'h0001_0000, 1'b1, 1'b1); plan.push_back(e);
    e.b = mk(32'h0001_0000, 32'd0, 32'h0001_0000, 1'b1, 1'b1); plan.push_back(e);
    e.b = mk(32'h0001_0000, 32'h0002_0000, 32'd0, 1'b1, 1'b1); plan.push_back(e);
    e.b = mk(32'd5, 32'd5, 32'd5, 1'b0, 1'b1); plan.push_back(e);
    e.typed = 1'b0;
    e.b = mk(32'h0001_0000, 32'hFFFF_FFFF, 32'd1, 1'b1, 1'b1); plan.push_back(e);
    e.b = mk(32'h0001_0000, 32'd1, 32'hFFFF_FFFF, 1'b1, 1'b0); plan.push_back(e);
    e.b = mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b0, 1'b0); plan.push_back(e);
    e.b = mk(32'd1, 32'h0002_0000, 32'h0001_8000, 1'b0, 1'b1); plan.push_back(e);
    e.b = mk(32'h0001_0000, 32'h0001_1000, 32'h0000_F000, 1'b1, 1'b0); plan.push_back(e);
    e.b = mk(32'h0001_0800, 32'h0001_1000, 32'h0000_F000, 1'b1, 1'b0); plan.push_back(e);
    e.b = mk(32'd0, 32'h0001_1000, 32'h0000_F000, 1'b0, 1'b0); plan.push_back(e);
    e.b = mk(32'h0001_0000, 32'h0001_1000, 32'h0000_F000, 1'b0, 1'b1); plan.push_back(e);
    e.b = mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b0); plan.push_back(e);
    e.b = mk(32'h0004_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, 1'b1); plan.push_back(e);
    foreach (plan[i]) begin
      if (plan[i].typed) begin
        keep_close   = last_close;
        keep_sum     = row_sum;
        keep_counted = row_counted;
        predict_bar(plan[i].b);
        typed_r = sums_due.pop_back();
        if (typed_r.variance_sum !== plan[i].r.variance_sum) begin
          $error("typed row %0d: variance_sum expected %h actual %h", i,
                 plan[i].r.variance_sum, typed_r.variance_sum);
          errors++;
        end
        if (typed_r.sum_valid !== plan[i].r.sum_valid) begin
          $error("typed row %0d: sum_valid expected %b actual %b", i,
                 plan[i].r.sum_valid, typed_r.sum_valid);
          errors++;
        end
        // put predictor state back; the bar goes through the normal path below
        last_close  = keep_close;
        row_sum     = keep_sum;
        row_counted = keep_counted;
      end
      send_bar(plan[i].b);
    end

    // random rows, cycling idle phases
    k = 0;
    while (k < N_RANDOM) begin
      phase = idle_phase_t'((k / 60) % 4);
      if ($urandom_range(0, 9) == 0) begin
        b = {$urandom, $urandom, $urandom, 2'($urandom)};
        send_bar(b);
        k++;
      end else begin
        len = $urandom_range(1, 8);
        for (int j = 0; j < len; j++) begin
          b = mk(rand_price(), rand_price(), rand_price(), j == 0, j == len - 1);
          send_bar(b);
          k++;
        end
      end
    end
    bar_valid <= 1'b0;
    phase <= PH_NONE;

    while (sums_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("garman_klass_variance_sum_unit_test: clean");
    else $display("garman_klass_variance_sum_unit_test: errors");
    $finish;
  end
endmodule
